[rtl/bsr_pkg.sv]
// Shared types, codes and constants of the BMP stream decoder.
package bsr_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int PALETTE_ENTRIES_DEF = 256;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // "BM" as it lands in a little-endian 16-bit word
  localparam logic [15:0] SIG_BM      = {8'h4D, 8'h42};
  localparam logic [31:0] HDR_TOTAL   = 32'd54;
  localparam logic [31:0] INFO_SIZE   = 32'd40;
  localparam logic [31:0] ROW_ROUND   = 32'd31;
  localparam logic [31:0] SIZE_CAP    = 32'(64 * 1024 * 1024);

  // APB register map
  localparam int          CFG_AW        = 3;
  localparam logic [2:0]  ADDR_FILE_LEN = 3'd0;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHECK, PH_PALETTE, PH_PIXELS, PH_PADDING, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {CK_IDLE, CK_LIMITS, CK_MUL, CK_SIZE} chk_state_t;

  typedef enum logic [1:0] {MD_IDX1, MD_IDX4, MD_IDX8, MD_DIRECT} pix_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        is_last;
  } out_beat_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
  } chk_res_t;

  typedef struct packed {
    logic       load;
    logic [3:0] count;
    pix_mode_t  mode;
    logic       last_row;
    logic [1:0] status;
  } job_ctl_t;

endpackage

[rtl/bsr_chan_if.sv]
// Valid/ready stream channel carrying one beat of type T.
interface bsr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/bmp_stream_to_rgb_pixels.sv]
// Top level: streaming BMP decoder, bytes in, RGB pixel beats out.
// A byte's pixels pass the job register, the palette read stage and output register.
// Throughput: one pixel beat per cycle at 1/4/8-bit depth while out_ch is ready;
//   a byte per cycle at 8/24-bit; a 1-bit or 4-bit byte waits on the single read port.
// After the 54th header byte input stalls until the header check (shift-add size) ends.
// Reset (rst_n, synchronous, active low) clears parse state and file_length; the palette
//   holds whatever was last written and needs no clearing pass.
module bmp_stream_to_rgb_pixels import bsr_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  bsr_chan_if.sink          in_ch,
  bsr_chan_if.source        out_ch
);
  localparam int CB     = COORD_BITS;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  // ---- configuration register
  logic [31:0] file_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_FILE_LEN) begin
      file_length_r <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FILE_LEN) ? file_length_r : 32'd0;

  // ---- parse state
  phase_t phase_r, phase_nxt;
  logic [31:0] byte_count_r, byte_count_nxt, pal_off;
  logic [CB-1:0] column_r, column_nxt, row_r, row_nxt, rem, col_add;
  logic [1:0] rbp_r, rbp_nxt, rbp_inc, trip_r, trip_nxt;
  logic [15:0] partial_r, partial_nxt;

  logic in_acc, job_free;
  logic [7:0] b;
  logic [3:0] ppb, n;
  logic row_last;

  // header checker
  logic hdr_shift, chk_start;
  chk_res_t chk_res;
  logic [31:0] offset;
  logic [CB-1:0] img_w, img_h;
  pix_mode_t mode;

  // pixel jobs and palette write side
  job_ctl_t job;
  logic [7:0] job_byte;
  logic [23:0] job_rgb;
  logic [CB-1:0] job_x, job_y;
  logic pal_we, pal_re;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [23:0] pal_wdata, pal_rdata;

  // input is held off only while the header check runs or the expander is busy
  assign in_ch.ready = (phase_r != PH_CHECK) && job_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.payload.data_byte;

  assign pal_off   = byte_count_r - HDR_TOTAL;
  assign pal_waddr = pal_off[PAL_AW+1:2];
  assign rem       = img_w - column_r;
  assign row_last  = ({1'b0, row_r} + 1'b1) >= {1'b0, img_h};
  assign rbp_inc   = rbp_r + 2'd1;

  // pixels this byte yields, clipped at the row end
  always_comb begin
    case (mode)
      MD_IDX1: ppb = 4'd8;
      MD_IDX4: ppb = 4'd2;
      MD_IDX8: ppb = 4'd1;
      default: ppb = (trip_r == 2'd2) ? 4'd1 : 4'd0;
    endcase
    n       = (rem < CB'(ppb)) ? 4'(rem) : ppb;
    col_add = column_r + CB'(n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      byte_count_r <= '0;
      column_r     <= '0;
      row_r        <= '0;
      rbp_r        <= '0;
      trip_r       <= '0;
      partial_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      rbp_r        <= rbp_nxt;
      trip_r       <= trip_nxt;
      partial_r    <= partial_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    rbp_nxt        = rbp_r;
    trip_nxt       = trip_r;
    partial_nxt    = partial_r;
    hdr_shift      = 1'b0;
    chk_start      = 1'b0;
    pal_we         = 1'b0;
    pal_wdata      = {b, partial_r};
    job            = '0;
    job.mode       = mode;
    job_byte       = b;
    job_rgb        = '0;
    job_x          = column_r;
    job_y          = img_h - 1'b1 - row_r;

    if (in_acc) begin
      if (byte_count_r != '1) byte_count_nxt = byte_count_r + 1'b1;
      case (phase_r)
        PH_HEADER: begin
          if (byte_count_r == '0 && file_length_r < HDR_TOTAL) begin
            // short file: reject on the very first byte
            job = '{load: 1'b1, count: 4'd1, mode: MD_DIRECT, last_row: 1'b0,
                    status: ST_INVALID};
            job_x = '0;
            job_y = '0;
            phase_nxt = PH_DONE;
          end else begin
            hdr_shift = 1'b1;
            if (byte_count_r == HDR_TOTAL - 1'b1) begin
              chk_start = 1'b1;
              phase_nxt = PH_CHECK;
            end
          end
        end
        PH_PALETTE: begin
          // lanes blue, green, red, reserved; write the entry on red
          case (pal_off[1:0])
            2'd0:    partial_nxt[7:0]  = b;
            2'd1:    partial_nxt[15:8] = b;
            2'd2:    pal_we = 1'b1;
            default: ;
          endcase
          if ({1'b0, byte_count_r} + 1'b1 >= {1'b0, offset}) begin
            column_nxt  = '0;
            row_nxt     = '0;
            rbp_nxt     = '0;
            trip_nxt    = '0;
            partial_nxt = '0;
            phase_nxt   = (img_w == '0 || img_h == '0) ? PH_DONE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (mode == MD_DIRECT) begin
            case (trip_r)
              2'd0: begin partial_nxt[7:0] = b; trip_nxt = 2'd1; end
              2'd1: begin partial_nxt[15:8] = b; trip_nxt = 2'd2; end
              default: begin
                job_rgb  = {b, partial_r[15:8], partial_r[7:0]};
                trip_nxt = 2'd0;
              end
            endcase
          end
          if (n != 4'd0) begin
            job.load     = 1'b1;
            job.count    = n;
            job.last_row = ({1'b0, row_r} + 1'b1) == {1'b0, img_h};
            job.status   = ST_OK;
          end
          column_nxt = col_add;
          rbp_nxt    = rbp_inc;
          if (col_add >= img_w) begin
            if (rbp_inc == 2'd0) begin
              column_nxt = '0;
              row_nxt    = row_r + 1'b1;
              trip_nxt   = '0;
              phase_nxt  = row_last ? PH_DONE : PH_PIXELS;
            end else begin
              phase_nxt = PH_PADDING;
            end
          end
        end
        PH_PADDING: begin
          rbp_nxt = rbp_inc;
          if (rbp_inc == 2'd0) begin
            column_nxt = '0;
            row_nxt    = row_r + 1'b1;
            trip_nxt   = '0;
            phase_nxt  = row_last ? PH_DONE : PH_PIXELS;
          end
        end
        default: ;
      endcase
    end

    if (phase_r == PH_CHECK && chk_res.done) begin
      if (chk_res.status != ST_OK) begin
        job = '{load: 1'b1, count: 4'd1, mode: MD_DIRECT, last_row: 1'b0,
                status: chk_res.status};
        job_x = '0;
        job_y = '0;
        phase_nxt = PH_DONE;
      end else if (offset > HDR_TOTAL) begin
        phase_nxt = PH_PALETTE;
      end else begin
        column_nxt  = '0;
        row_nxt     = '0;
        rbp_nxt     = '0;
        trip_nxt    = '0;
        partial_nxt = '0;
        phase_nxt   = (img_w == '0 || img_h == '0) ? PH_DONE : PH_PIXELS;
      end
    end
  end

  bsr_hdr_chk #(.COORD_BITS(CB)) u_hdr_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (hdr_shift),
    .shift_byte (b),
    .start      (chk_start),
    .file_length(file_length_r),
    .res        (chk_res),
    .offset     (offset),
    .img_w      (img_w),
    .img_h      (img_h),
    .mode       (mode)
  );

  bsr_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(pal_waddr),
    .wdata(pal_wdata),
    .re   (pal_re),
    .raddr(pal_raddr),
    .rdata(pal_rdata)
  );

  bsr_pix_out #(.COORD_BITS(CB), .PAL_AW(PAL_AW)) u_pix_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (job),
    .job_byte(job_byte),
    .job_rgb (job_rgb),
    .job_x   (job_x),
    .job_y   (job_y),
    .img_w   (img_w),
    .img_h   (img_h),
    .job_free(job_free),
    .rd_en   (pal_re),
    .rd_addr (pal_raddr),
    .rd_data (pal_rdata),
    .out_ch  (out_ch)
  );
endmodule

[rtl/bsr_ram.sv]
// Generic single-port-write, registered-read RAM.
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[rtl/bsr_hdr_chk.sv]
// Header capture and multi-cycle header validation.
module bsr_hdr_chk import bsr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [7:0]            shift_byte,
  input  logic                  start,
  input  logic [31:0]           file_length,
  output chk_res_t              res,
  output logic [31:0]           offset,
  output logic [COORD_BITS-1:0] img_w,
  output logic [COORD_BITS-1:0] img_h,
  output pix_mode_t             mode
);
  localparam int DW_W   = COORD_BITS + 6;
  localparam int RS_W   = COORD_BITS + 3;
  localparam int PROD_W = RS_W + COORD_BITS;
  localparam int CMP_W  = (PROD_W > 32) ? PROD_W : 32;
  localparam int CNT_W  = $clog2(COORD_BITS);
  localparam int HDR_W  = 8 * 54;

  logic [HDR_W-1:0] hdr_r;
  logic [15:0] sig, depth;
  logic [31:0] fsize, info, width, height, compr, data_len, pal_bytes;
  logic [DW_W-1:0] wz, dw;
  logic [RS_W-1:0] row_bytes;
  logic depth_ok;

  chk_state_t st_r, st_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt, prod_r, prod_nxt;
  logic [COORD_BITS-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // byte k of the header ends up at bits [8k+7:8k]
  always_ff @(posedge clk) begin
    if (shift_en) begin
      hdr_r <= {shift_byte, hdr_r[HDR_W-1:8]};
    end
  end

  assign sig    = hdr_r[15:0];
  assign fsize  = hdr_r[47:16];
  assign offset = hdr_r[111:80];
  assign info   = hdr_r[143:112];
  assign width  = hdr_r[175:144];
  assign height = hdr_r[207:176];
  assign depth  = hdr_r[239:224];
  assign compr  = hdr_r[271:240];
  assign img_w  = width[COORD_BITS-1:0];
  assign img_h  = height[COORD_BITS-1:0];
  assign data_len = fsize - offset;

  assign depth_ok = (depth == 16'd1) || (depth == 16'd4) || (depth == 16'd8) ||
                    (depth == 16'd24);

  always_comb begin
    case (depth)
      16'd1:   mode = MD_IDX1;
      16'd4:   mode = MD_IDX4;
      16'd8:   mode = MD_IDX8;
      default: mode = MD_DIRECT;
    endcase
  end

  // bits per row, then rounded up to whole 32-bit words, in bytes
  assign wz = DW_W'(img_w);
  always_comb begin
    case (mode)
      MD_IDX1: begin dw = wz; pal_bytes = 32'd8; end
      MD_IDX4: begin dw = wz << 2; pal_bytes = 32'd64; end
      MD_IDX8: begin dw = wz << 3; pal_bytes = 32'd1024; end
      default: begin dw = (wz << 4) + (wz << 3); pal_bytes = 32'd0; end
    endcase
  end
  assign row_bytes = RS_W'(((dw + DW_W'(ROW_ROUND)) >> 5) << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
    cnt_r    <= cnt_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    cnt_nxt    = cnt_r;
    res        = '0;
    case (st_r)
      CK_IDLE: begin
        if (start) st_nxt = CK_LIMITS;
      end
      CK_LIMITS: begin
        if (sig != SIG_BM || fsize != file_length || fsize < offset) begin
          res = '{done: 1'b1, status: ST_INVALID};
          st_nxt = CK_IDLE;
        end else if (compr != 32'd0 || info != INFO_SIZE || !depth_ok ||
                     (width >> COORD_BITS) != 32'd0 ||
                     (height >> COORD_BITS) != 32'd0) begin
          res = '{done: 1'b1, status: ST_UNSUPPORTED};
          st_nxt = CK_IDLE;
        end else begin
          mcand_nxt  = PROD_W'(row_bytes);
          mplier_nxt = img_h;
          prod_nxt   = '0;
          cnt_nxt    = '0;
          st_nxt     = CK_MUL;
        end
      end
      CK_MUL: begin
        // shift-add: row size times height, one bit of height a cycle
        if (mplier_r[0]) prod_nxt = prod_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_BITS - 1)) st_nxt = CK_SIZE;
      end
      CK_SIZE: begin
        st_nxt = CK_IDLE;
        res.done = 1'b1;
        if (CMP_W'(prod_r) > CMP_W'(SIZE_CAP) || CMP_W'(data_len) != CMP_W'(prod_r) ||
            offset < HDR_TOTAL) begin
          res.status = ST_INVALID;
        end else if (offset > HDR_TOTAL) begin
          res.status = (offset - HDR_TOTAL != pal_bytes) ? ST_INVALID : ST_OK;
        end else begin
          // indexed depth needs a palette
          res.status = (mode != MD_DIRECT) ? ST_INVALID : ST_OK;
        end
      end
      default: st_nxt = CK_IDLE;
    endcase
  end
endmodule

[rtl/bsr_pix_out.sv]
// Pixel expander, palette read stage and output register.
module bsr_pix_out import bsr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int PAL_AW     = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  job_ctl_t              job,
  input  logic [7:0]            job_byte,
  input  logic [23:0]           job_rgb,
  input  logic [COORD_BITS-1:0] job_x,
  input  logic [COORD_BITS-1:0] job_y,
  input  logic [COORD_BITS-1:0] img_w,
  input  logic [COORD_BITS-1:0] img_h,
  output logic                  job_free,
  output logic                  rd_en,
  output logic [PAL_AW-1:0]     rd_addr,
  input  logic [23:0]           rd_data,
  bsr_chan_if.source            out_ch
);
  logic [3:0] cnt_r;
  pix_mode_t mode_r;
  logic [7:0] byte_r, byte_shift;
  logic [23:0] rgb_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic lastrow_r;
  logic [1:0] status_r;

  logic s1_v_r, s1_last_r, s1_direct_r;
  logic [1:0] s1_status_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [23:0] s1_rgb_r, s1_pix;

  logic out_v_r;
  out_beat_t out_r;
  logic adv, issue, ok;

  assign adv      = !out_v_r || out_ch.ready;
  assign issue    = (cnt_r != 4'd0) && (!s1_v_r || adv);
  assign job_free = (cnt_r == 4'd0) || (cnt_r == 4'd1 && issue);
  assign rd_en    = issue && (mode_r != MD_DIRECT);

  always_comb begin
    case (mode_r)
      MD_IDX1: begin rd_addr = PAL_AW'(byte_r[7]); byte_shift = byte_r << 1; end
      MD_IDX4: begin rd_addr = PAL_AW'(byte_r[7:4]); byte_shift = byte_r << 4; end
      default: begin rd_addr = PAL_AW'(byte_r); byte_shift = byte_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job.load) cnt_r <= job.count;
      else if (issue) cnt_r <= cnt_r - 4'd1;
      s1_v_r  <= issue ? 1'b1 : (adv ? 1'b0 : s1_v_r);
      if (adv) out_v_r <= s1_v_r;
    end
  end

  assign s1_pix = s1_direct_r ? s1_rgb_r : rd_data;
  assign ok     = (s1_status_r == ST_OK);

  always_ff @(posedge clk) begin
    if (job.load) begin
      mode_r    <= job.mode;
      byte_r    <= job_byte;
      rgb_r     <= job_rgb;
      x_r       <= job_x;
      y_r       <= job_y;
      lastrow_r <= job.last_row;
      status_r  <= job.status;
    end else if (issue) begin
      byte_r <= byte_shift;
      x_r    <= x_r + 1'b1;
    end
    if (issue) begin
      s1_status_r <= status_r;
      s1_x_r      <= x_r;
      s1_y_r      <= y_r;
      s1_direct_r <= (mode_r == MD_DIRECT);
      s1_rgb_r    <= rgb_r;
      s1_last_r   <= (status_r != ST_OK) || (lastrow_r && x_r == img_w - 1'b1);
    end
    if (adv && s1_v_r) begin
      out_r.status       <= s1_status_r;
      out_r.pixel_x      <= 16'(s1_x_r);
      out_r.pixel_y      <= 16'(s1_y_r);
      out_r.red          <= s1_pix[23:16];
      out_r.green        <= s1_pix[15:8];
      out_r.blue         <= s1_pix[7:0];
      out_r.image_width  <= ok ? 16'(img_w) : 16'd0;
      out_r.image_height <= ok ? 16'(img_h) : 16'd0;
      out_r.is_last      <= s1_last_r;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = out_r;
endmodule

[rtl/bsr_checker.sv]
// Port-level assertions for the BMP decoder, bound to the top level.
module bsr_checker import bsr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_payload
);
  // error beats always close the stream
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.status != ST_OK |-> out_payload.is_last)
    else $error("error beat without is_last");

  // error beats carry zero pixel_x, image_width and red
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.status != ST_OK |->
      out_payload.pixel_x == 16'd0 && out_payload.image_width == 16'd0 &&
      out_payload.red == 8'd0)
    else $error("error beat with non-zero fields");

  // nothing follows the closing beat
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_payload.is_last |=> !out_valid)
    else $error("beat after the closing beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled beat changed");
endmodule

bind bmp_stream_to_rgb_pixels bsr_checker u_bsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_payload(out_ch.payload)
);
